### hdl/tdrs_pkg.sv
// Shared types and constants for the time-of-day relay scheduler.
// No dependencies; imported by every module of the block.
package tdrs_pkg;

   localparam int MINUTE_W   = 11;
   localparam int DAY_W      = 5;
   localparam int DIST_W     = 16;
   localparam int OVR_W      = 2;
   localparam int WINDOW_W   = 12;
   localparam int SLOT_W     = 12;
   localparam int SLOT_BANK_W = 48;
   localparam int MAX_SLOTS  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [WINDOW_W-1:0] MINUTES_PER_DAY = 12'd1440;

   localparam logic [OVR_W-1:0] OVR_AUTO = 2'b11;
   localparam logic [OVR_W-1:0] OVR_ON   = 2'b01;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LIGHT_START  = 3'd0,
      REG_LIGHT_END    = 3'd1,
      REG_SLOT_MINUTES = 3'd2,
      REG_CUTOFF       = 3'd3,
      REG_SLOTS_LOW    = 3'd4,
      REG_SLOTS_HIGH   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [WINDOW_W-1:0] light_start;
      logic signed [WINDOW_W-1:0] light_end;
      logic [MINUTE_W-1:0]        slot_minutes;
      logic [DIST_W-1:0]          cutoff;
      logic [SLOT_BANK_W-1:0]     slots_low;
      logic [SLOT_BANK_W-1:0]     slots_high;
   } cfg_type;

   typedef struct packed {
      op_type                  operation;
      logic                    clock_valid;
      logic [MINUTE_W-1:0]     minute_of_day;
      logic [DAY_W-1:0]        day_of_month;
      logic [DIST_W-1:0]       water_distance;
      logic signed [OVR_W-1:0] light_override_value;
      logic signed [OVR_W-1:0] pump_override_value;
   } item_type;

   typedef struct packed {
      logic light_hit;
      logic pump_hit;
   } win_type;

   typedef struct packed {
      logic light_on;
      logic pump_on;
      logic light_changed;
      logic pump_changed;
      logic safety_cut;
      logic overrides_cleared;
   } result_type;

endpackage

### hdl/tdrs_window.sv
// Light window and pump slot window compares for one minute of day.
// Depends on tdrs_pkg; purely combinational.
module tdrs_window import tdrs_pkg::*; #(
   parameter int NUM_SLOTS = 8
) (
   input  cfg_type             cfg,
   input  logic [MINUTE_W-1:0] minute,
   output win_type             hit
);

   logic [SLOT_W*MAX_SLOTS-1:0] slots;
   logic [NUM_SLOTS-1:0]        slot_hit;
   logic [WINDOW_W-1:0]         now_ext;
   logic [WINDOW_W-1:0]         lstart;
   logic [WINDOW_W-1:0]         lend;
   logic                        light_set;

   assign slots   = {cfg.slots_high, cfg.slots_low};
   assign now_ext = {1'b0, minute};

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
      logic [SLOT_W-1:0]   slot;
      logic [WINDOW_W-1:0] start;
      logic [WINDOW_W-1:0] stop;
      logic [WINDOW_W-1:0] stop_wrap;
      logic                wraps;

      assign slot      = slots[i*SLOT_W +: SLOT_W];
      assign start     = {1'b0, slot[MINUTE_W-1:0]};
      assign stop      = start + {1'b0, cfg.slot_minutes};
      assign stop_wrap = stop - MINUTES_PER_DAY;
      assign wraps     = stop > MINUTES_PER_DAY;
      assign slot_hit[i] = slot[SLOT_W-1] &&
         (wraps ? (now_ext >= start || now_ext < stop_wrap)
                : (now_ext >= start && now_ext < stop));
   end

   // both bounds non-negative once set, so unsigned compares hold
   assign lstart    = cfg.light_start;
   assign lend      = cfg.light_end;
   assign light_set = !lstart[WINDOW_W-1] && !lend[WINDOW_W-1];

   assign hit.light_hit = light_set &&
      ((lstart <= lend) ? (now_ext >= lstart && now_ext < lend)
                        : (now_ext >= lstart || now_ext < lend));
   assign hit.pump_hit  = |slot_hit;

endmodule

### hdl/tdrs_core.sv
// Relay decision, override and midnight state, and the result register.
// Depends on tdrs_pkg; window hits come from tdrs_window.
module tdrs_core import tdrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  item_type          item,
   input  win_type           hit,
   input  logic [DIST_W-1:0] cutoff,
   input  logic              rsp_stall,
   output logic              take,
   output logic              rsp_valid,
   output result_type        rsp
);

   logic              light_state_ff, light_state_in;
   logic              pump_state_ff, pump_state_in;
   logic [OVR_W-1:0]  light_ovr_ff, light_ovr_in;
   logic [OVR_W-1:0]  pump_ovr_ff, pump_ovr_in;
   logic [DAY_W-1:0]  last_day_ff, last_day_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   logic              fire;
   logic              midnight;
   logic              cut;

   assign take = !rsp_valid_ff || !rsp_stall;
   assign fire = item_valid && take;
   assign cut  = item.water_distance >= cutoff;
   assign midnight = item.clock_valid && (item.minute_of_day == '0) &&
                     (last_day_ff != item.day_of_month);

   always_comb begin
      light_state_in = light_state_ff;
      pump_state_in  = pump_state_ff;
      light_ovr_in   = light_ovr_ff;
      pump_ovr_in    = pump_ovr_ff;
      last_day_in    = last_day_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (item.operation == OP_LOAD) begin
            light_ovr_in = item.light_override_value;
            pump_ovr_in  = item.pump_override_value;
         end else begin
            if (!light_ovr_ff[OVR_W-1])
               light_state_in = (light_ovr_ff == OVR_ON);
            else if (item.clock_valid)
               light_state_in = hit.light_hit;

            if (cut)
               pump_state_in = 1'b0;
            else if (!pump_ovr_ff[OVR_W-1])
               pump_state_in = (pump_ovr_ff == OVR_ON);
            else if (item.clock_valid)
               pump_state_in = hit.pump_hit;

            rsp_in.light_changed = light_state_in != light_state_ff;
            rsp_in.pump_changed  = pump_state_in != pump_state_ff;
            rsp_in.safety_cut    = cut;

            if (midnight) begin
               last_day_in = item.day_of_month;
               if (!light_ovr_ff[OVR_W-1] || !pump_ovr_ff[OVR_W-1]) begin
                  light_ovr_in = OVR_AUTO;
                  pump_ovr_in  = OVR_AUTO;
                  rsp_in.overrides_cleared = 1'b1;
               end
            end
         end
         rsp_in.light_on = light_state_in;
         rsp_in.pump_on  = pump_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_state_ff <= 1'b0;
         pump_state_ff  <= 1'b0;
         light_ovr_ff   <= OVR_AUTO;
         pump_ovr_ff    <= OVR_AUTO;
         last_day_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         light_state_ff <= light_state_in;
         pump_state_ff  <= pump_state_in;
         light_ovr_ff   <= light_ovr_in;
         pump_ovr_ff    <= pump_ovr_in;
         last_day_ff    <= last_day_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_cut_forces_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.safety_cut |-> !rsp_ff.pump_on)
      else $error("safety cut with pump on");

   a_clear_to_auto: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_in.overrides_cleared |=>
         light_ovr_ff == OVR_AUTO && pump_ovr_ff == OVR_AUTO)
      else $error("overrides not cleared");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      $past(fire) |-> rsp_ff.light_on == light_state_ff &&
                      rsp_ff.pump_on == pump_state_ff)
      else $error("result disagrees with relay state");

   a_hold_under_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result lost under stall");

endmodule

### hdl/time_of_day_relay_scheduler.sv
// Top level of the time-of-day relay scheduler: registers, input stage, wiring.
// Depends on tdrs_pkg, tdrs_window and tdrs_core.
//
// Usage:
//   req_*  : one transaction per item. operation 0 is a tick that updates the
//            light and pump relays; operation 1 loads both override values.
//   rsp_*  : exactly one result transaction per accepted item, in order.
//   csr_*  : register writes (index, data); csr_ready is always high. Write
//            only while no item is in flight.
// Pipeline: an accepted item passes the input register, then the result
// register, with the window compares between them.
// Throughput: one item per cycle while rsp_stall is low; the relay and
// override state update at the same edge that loads the result register.
// Stall: while rsp_stall holds a waiting result, one more item is taken into
// the input register; req_stall then rises until the result is taken.
// Reset: relays off, overrides automatic, no day cleared yet, registers at
// their defaults, both stages empty.
module time_of_day_relay_scheduler import tdrs_pkg::*; #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic                       req_clock_valid,
   input  logic [MINUTE_W-1:0]        req_minute_of_day,
   input  logic [DAY_W-1:0]           req_day_of_month,
   input  logic [DIST_W-1:0]          req_water_distance,
   input  logic signed [OVR_W-1:0]    req_light_override_value,
   input  logic signed [OVR_W-1:0]    req_pump_override_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_light_on,
   output logic                       rsp_pump_on,
   output logic                       rsp_light_changed,
   output logic                       rsp_pump_changed,
   output logic                       rsp_safety_cut,
   output logic                       rsp_overrides_cleared,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   cfg_type    cfg_ff, cfg_in;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   logic       take;
   logic       req_fire;
   win_type    hit;
   result_type rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_LIGHT_START:  cfg_in.light_start  = csr_data[WINDOW_W-1:0];
            REG_LIGHT_END:    cfg_in.light_end    = csr_data[WINDOW_W-1:0];
            REG_SLOT_MINUTES: cfg_in.slot_minutes = csr_data[MINUTE_W-1:0];
            REG_CUTOFF:       cfg_in.cutoff       = csr_data[DIST_W-1:0];
            REG_SLOTS_LOW:    cfg_in.slots_low    = csr_data[SLOT_BANK_W-1:0];
            REG_SLOTS_HIGH:   cfg_in.slots_high   = csr_data[SLOT_BANK_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = item_valid_ff && !take;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      item_in.operation            = op_type'(req_operation);
      item_in.clock_valid          = req_clock_valid;
      item_in.minute_of_day        = req_minute_of_day;
      item_in.day_of_month         = req_day_of_month;
      item_in.water_distance       = req_water_distance;
      item_in.light_override_value = req_light_override_value;
      item_in.pump_override_value  = req_pump_override_value;
      if (req_fire)
         item_valid_in = 1'b1;
      else if (take)
         item_valid_in = 1'b0;
      else
         item_valid_in = item_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_start  <= '1;
         cfg_ff.light_end    <= '1;
         cfg_ff.slot_minutes <= 11'd5;
         cfg_ff.cutoff       <= '1;
         cfg_ff.slots_low    <= '0;
         cfg_ff.slots_high   <= '0;
         item_valid_ff       <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         item_ff <= item_in;
   end

   tdrs_window #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_window (
      .cfg    (cfg_ff),
      .minute (item_ff.minute_of_day),
      .hit    (hit)
   );

   tdrs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .hit        (hit),
      .cutoff     (cfg_ff.cutoff),
      .rsp_stall  (rsp_stall),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_light_on          = rsp.light_on;
   assign rsp_pump_on           = rsp.pump_on;
   assign rsp_light_changed     = rsp.light_changed;
   assign rsp_pump_changed      = rsp.pump_changed;
   assign rsp_safety_cut        = rsp.safety_cut;
   assign rsp_overrides_cleared = rsp.overrides_cleared;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for time_of_day_relay_scheduler: a directed table, then random
// transactions under several register settings, scored against a built-in relay predictor.
// Depends on tdrs_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module testbench;
   import tdrs_pkg::*;

   localparam int ITEMS_PER_SEGMENT = 258;
   localparam int SEGMENTS          = 6;
   localparam int HOLD_CYCLES       = 60;
   localparam int REPORT_LIMIT      = 40;
   localparam int RECONFIG_ROW      = 13;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd6;
   localparam logic [SLOT_W-1:0]    SLOT_VALID = 12'h800;

   typedef enum {SET_TYPICAL, SET_RAW, SET_LOW, SET_HIGH} settings_type;

   typedef struct packed {
      item_type   item;
      logic       typed;
      result_type want;
   } step_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_operation;
   logic                    req_clock_valid;
   logic [MINUTE_W-1:0]     req_minute_of_day;
   logic [DAY_W-1:0]        req_day_of_month;
   logic [DIST_W-1:0]       req_water_distance;
   logic signed [OVR_W-1:0] req_light_override_value;
   logic signed [OVR_W-1:0] req_pump_override_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_light_on;
   logic                    rsp_pump_on;
   logic                    rsp_light_changed;
   logic                    rsp_pump_changed;
   logic                    rsp_safety_cut;
   logic                    rsp_overrides_cleared;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   // predictor copy of registers and state
   logic signed [WINDOW_W-1:0] light_begin;
   logic signed [WINDOW_W-1:0] light_stop;
   logic [MINUTE_W-1:0]        slot_len;
   logic [DIST_W-1:0]          cutoff;
   logic [SLOT_BANK_W-1:0]     slots_lo;
   logic [SLOT_BANK_W-1:0]     slots_hi;
   logic                       light_relay;
   logic                       pump_relay;
   logic [OVR_W-1:0]           light_ovr;
   logic [OVR_W-1:0]           pump_ovr;
   logic [DAY_W-1:0]           last_clear_day;

   result_type   relay_results_due[$];
   step_row_type directed_rows[$];
   int           failure_count  = 0;
   int           sender_gap_pct = 16;
   int           sink_stall_pct = 72;
   int           hold_requests  = 0;
   int           walk_minute    = 0;
   int           walk_day       = 1;

   string result_field_names[6] = '{"overrides_cleared", "safety_cut", "pump_changed",
                                    "light_changed", "pump_on", "light_on"};

   time_of_day_relay_scheduler dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic light_in_window(logic [MINUTE_W-1:0] now);
      int s, e, n;
      s = light_begin;
      e = light_stop;
      n = now;
      if (s < 0 || e < 0) return 1'b0;
      if (s <= e) return n >= s && n < e;
      return n >= s || n < e;
   endfunction

   function automatic logic pump_in_slot(logic [MINUTE_W-1:0] now);
      logic [2*SLOT_BANK_W-1:0] bank;
      logic [SLOT_W-1:0]        slot;
      int                       first, last, n, day_len;
      bank    = {slots_hi, slots_lo};
      n       = now;
      day_len = int'(MINUTES_PER_DAY);
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot = bank[SLOT_W*i +: SLOT_W];
         if (slot[SLOT_W-1]) begin
            first = slot[MINUTE_W-1:0];
            last  = first + int'(slot_len);
            if (last <= day_len) begin
               if (n >= first && n < last) return 1'b1;
            end else if (n >= first || n < last - day_len) begin
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic result_type schedule_relays(item_type it);
      result_type r;
      logic       light_next, pump_next;
      r = '0;
      if (it.operation == OP_LOAD) begin
         light_ovr = it.light_override_value;
         pump_ovr  = it.pump_override_value;
      end else begin
         light_next = light_relay;
         pump_next  = pump_relay;
         if (!light_ovr[OVR_W-1]) light_next = (light_ovr == OVR_ON);
         else if (it.clock_valid) light_next = light_in_window(it.minute_of_day);
         r.safety_cut = (it.water_distance >= cutoff);
         if (r.safety_cut) pump_next = 1'b0;
         else if (!pump_ovr[OVR_W-1]) pump_next = (pump_ovr == OVR_ON);
         else if (it.clock_valid) pump_next = pump_in_slot(it.minute_of_day);
         r.light_changed = (light_next != light_relay);
         r.pump_changed  = (pump_next != pump_relay);
         light_relay     = light_next;
         pump_relay      = pump_next;
         // midnight of a new day drops any forced override
         if (it.clock_valid && it.minute_of_day == '0 && last_clear_day != it.day_of_month) begin
            last_clear_day = it.day_of_month;
            if (!light_ovr[OVR_W-1] || !pump_ovr[OVR_W-1]) begin
               light_ovr           = OVR_AUTO;
               pump_ovr            = OVR_AUTO;
               r.overrides_cleared = 1'b1;
            end
         end
      end
      r.light_on = light_relay;
      r.pump_on  = pump_relay;
      return r;
   endfunction

   function automatic item_type tick_item(logic valid, int minute, int day, int dist_value);
      item_type it;
      it                      = '0;
      it.operation            = OP_TICK;
      it.clock_valid          = valid;
      it.minute_of_day        = MINUTE_W'(minute);
      it.day_of_month         = DAY_W'(day);
      it.water_distance       = DIST_W'(dist_value);
      it.light_override_value = OVR_AUTO;
      it.pump_override_value  = OVR_AUTO;
      return it;
   endfunction

   function automatic item_type load_item(int light_value, int pump_value);
      item_type it;
      it                      = '0;
      it.operation            = OP_LOAD;
      it.light_override_value = OVR_W'(light_value);
      it.pump_override_value  = OVR_W'(pump_value);
      return it;
   endfunction

   // mostly a clock walking through the days, the rest noise
   function automatic item_type next_random_item();
      item_type it;
      int       pick, advance, distance;
      pick                    = $urandom_range(99, 0);
      it.operation            = (pick < 10) ? OP_LOAD : OP_TICK;
      it.clock_valid          = ($urandom_range(99, 0) < 88);
      it.light_override_value = OVR_W'($urandom_range(3, 0));
      it.pump_override_value  = OVR_W'($urandom_range(3, 0));
      if (pick < 75) begin
         advance = ($urandom_range(9, 0) == 0) ? $urandom_range(1439, 0)
                                               : $urandom_range(40, 0);
         walk_minute += advance;
         if (walk_minute >= int'(MINUTES_PER_DAY)) begin
            walk_minute = ($urandom_range(1, 0) == 1) ? 0
                                                       : walk_minute - int'(MINUTES_PER_DAY);
            walk_day = (walk_day >= 31) ? 1 : walk_day + 1;
         end
         it.minute_of_day = MINUTE_W'(walk_minute);
         it.day_of_month  = DAY_W'(walk_day);
      end else begin
         it.minute_of_day = ($urandom_range(3, 0) == 0) ? '0 : MINUTE_W'($urandom);
         it.day_of_month  = DAY_W'($urandom);
      end
      pick = $urandom_range(99, 0);
      if (pick < 15) distance = int'(cutoff) + int'($urandom_range(6, 0)) - 3;
      else if (pick < 30) distance = int'($urandom_range(65535, 0));
      else if (cutoff == '0) distance = 0;
      else distance = int'($urandom_range(int'(cutoff) - 1, 0));
      if (distance < 0) distance = 0;
      if (distance > 65535) distance = 65535;
      it.water_distance = DIST_W'(distance);
      return it;
   endfunction

   task automatic offer_item(item_type it, logic typed, result_type want);
      result_type predicted;
      while ($urandom_range(99, 0) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_operation            <= it.operation;
      req_clock_valid          <= it.clock_valid;
      req_minute_of_day        <= it.minute_of_day;
      req_day_of_month         <= it.day_of_month;
      req_water_distance       <= it.water_distance;
      req_light_override_value <= it.light_override_value;
      req_pump_override_value  <= it.pump_override_value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = schedule_relays(it);
      relay_results_due.push_back(typed ? want : predicted);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_LIGHT_START:  light_begin = data[WINDOW_W-1:0];
         REG_LIGHT_END:    light_stop  = data[WINDOW_W-1:0];
         REG_SLOT_MINUTES: slot_len    = data[MINUTE_W-1:0];
         REG_CUTOFF:       cutoff      = data[DIST_W-1:0];
         REG_SLOTS_LOW:    slots_lo    = data[SLOT_BANK_W-1:0];
         REG_SLOTS_HIGH:   slots_hi    = data[SLOT_BANK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(logic [WINDOW_W-1:0] ls, logic [WINDOW_W-1:0] le,
                                 logic [MINUTE_W-1:0] sm, logic [DIST_W-1:0] co,
                                 logic [SLOT_BANK_W-1:0] lo, logic [SLOT_BANK_W-1:0] hi);
      write_reg(REG_LIGHT_START, CSR_DATA_W'(ls));
      write_reg(REG_LIGHT_END, CSR_DATA_W'(le));
      write_reg(REG_SLOT_MINUTES, CSR_DATA_W'(sm));
      write_reg(REG_CUTOFF, CSR_DATA_W'(co));
      write_reg(REG_SLOTS_LOW, lo);
      write_reg(REG_SLOTS_HIGH, hi);
      write_reg(REG_UNUSED, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (relay_results_due.size() != 0) @(posedge clock);
   endtask

   // result channel back-pressure, with long hold-offs on request
   initial begin
      int holds_served, hold_left;
      holds_served = 0;
      hold_left    = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < sink_stall_pct);
         end
      end
   end

   initial begin
      result_type seen, due;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen = {rsp_light_on, rsp_pump_on, rsp_light_changed, rsp_pump_changed,
                    rsp_safety_cut, rsp_overrides_cleared};
            if (relay_results_due.size() == 0) begin
               if (failure_count < REPORT_LIMIT)
                  $display("%0t ns: result transaction with none pending, got %b", $time, seen);
               failure_count++;
            end else begin
               due = relay_results_due.pop_front();
               if (seen !== due) begin
                  if (failure_count < REPORT_LIMIT)
                     for (int b = 5; b >= 0; b--)
                        if (seen[b] !== due[b])
                           $display("%0t ns: %s expected %0b, got %0b", $time,
                                    result_field_names[b], due[b], seen[b]);
                  failure_count++;
               end
            end
         end
      end
   end

   initial begin
      logic [WINDOW_W-1:0]    ls, le;
      logic [MINUTE_W-1:0]    sm;
      logic [DIST_W-1:0]      co;
      logic [SLOT_BANK_W-1:0] lo, hi;
      settings_type           plan;

      reset                    <= 1'b1;
      req_valid                <= 1'b0;
      req_operation            <= OP_TICK;
      req_clock_valid          <= 1'b0;
      req_minute_of_day        <= '0;
      req_day_of_month         <= '0;
      req_water_distance       <= '0;
      req_light_override_value <= '0;
      req_pump_override_value  <= '0;
      csr_valid                <= 1'b0;
      csr_index                <= '0;
      csr_data                 <= '0;
      light_begin    = -12'sd1;
      light_stop     = -12'sd1;
      slot_len       = 11'd5;
      cutoff         = 16'hFFFF;
      slots_lo       = '0;
      slots_hi       = '0;
      light_relay    = 1'b0;
      pump_relay     = 1'b0;
      light_ovr      = OVR_AUTO;
      pump_ovr       = OVR_AUTO;
      last_clear_day = '0;

      // result bits: light_on pump_on light_chg pump_chg cut cleared
      directed_rows.push_back({tick_item(1'b1, 0, 1, 0), 1'b1, 6'b000000});
      directed_rows.push_back({tick_item(1'b0, 0, 1, 65535), 1'b1, 6'b000010});
      directed_rows.push_back({load_item(1, 1), 1'b1, 6'b000000});
      directed_rows.push_back({tick_item(1'b0, 2047, 31, 100), 1'b1, 6'b111100});
      directed_rows.push_back({tick_item(1'b1, 0, 1, 0), 1'b1, 6'b110000});
      directed_rows.push_back({tick_item(1'b1, 0, 2, 65535), 1'b1, 6'b100111});
      directed_rows.push_back({tick_item(1'b1, 720, 2, 0), 1'b1, 6'b001000});
      directed_rows.push_back({load_item(-2, 0), 1'b1, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 5, 3, 0), 1'b1, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 0, 0, 65534), 1'b1, 6'b000001});
      directed_rows.push_back({load_item(1, -1), 1'b1, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 0, 0, 0), 1'b1, 6'b101000});
      directed_rows.push_back({tick_item(1'b1, 0, 5, 0), 1'b1, 6'b100001});
      // window 23:00 to 01:00, slots at 23:50 (wraps), 01:40 and an out-of-range start
      directed_rows.push_back({tick_item(1'b1, 1400, 5, 0), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 30, 5, 999), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 60, 5, 1000), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 1439, 5, 0), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 1435, 5, 0), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 10, 5, 0), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 100, 5, 0), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 129, 5, 0), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 130, 5, 0), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b0, 700, 5, 0), 1'b0, 6'b000000});
      directed_rows.push_back({load_item(1, 1), 1'b0, 6'b000000});
      directed_rows.push_back({tick_item(1'b1, 700, 5, 1000), 1'b0, 6'b000000});
      directed_rows.push_back({load_item(-1, -1), 1'b0, 6'b000000});

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (i == RECONFIG_ROW) begin
            req_valid <= 1'b0;
            drain_results();
            write_settings(12'd1380, 12'd60, 11'd30, 16'd1000,
                           {12'h000, 12'd500, SLOT_VALID | 12'd100, SLOT_VALID | 12'd1430},
                           {SLOT_VALID | 12'd1500, 12'h000, 12'h000, 12'h000});
         end
         offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
      req_valid <= 1'b0;

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_results();
         sender_gap_pct = (seg < 2) ? 16 : (seg < 4) ? 72 : 0;
         sink_stall_pct <= (seg < 2) ? 72 : (seg < 4) ? 16 : 0;
         case (seg)
            1:       plan = SET_RAW;
            3:       plan = SET_LOW;
            5:       plan = SET_HIGH;
            default: plan = SET_TYPICAL;
         endcase
         case (plan)
            SET_RAW: begin
               ls = WINDOW_W'($urandom);
               le = WINDOW_W'($urandom);
               sm = MINUTE_W'($urandom);
               co = DIST_W'($urandom);
               lo = SLOT_BANK_W'({$urandom, $urandom});
               hi = SLOT_BANK_W'({$urandom, $urandom});
            end
            SET_LOW: begin
               ls = 12'h800;
               le = '0;
               sm = '0;
               co = 16'd1;
               lo = {4{SLOT_VALID}};
               hi = '0;
            end
            SET_HIGH: begin
               ls = 12'h7FF;
               le = 12'h7FF;
               sm = '1;
               co = '1;
               lo = '1;
               hi = '1;
            end
            default: begin
               ls = ($urandom_range(9, 0) == 0) ? '1 : WINDOW_W'($urandom_range(1439, 0));
               le = ($urandom_range(9, 0) == 0) ? '1 : WINDOW_W'($urandom_range(1439, 0));
               sm = MINUTE_W'($urandom_range(240, 1));
               co = DIST_W'($urandom_range(3000, 200));
               for (int k = 0; k < 4; k++) begin
                  lo[SLOT_W*k +: SLOT_W] = {1'($urandom), MINUTE_W'($urandom_range(1439, 0))};
                  hi[SLOT_W*k +: SLOT_W] = {1'($urandom), MINUTE_W'($urandom_range(1439, 0))};
               end
            end
         endcase
         write_settings(ls, le, sm, co, lo, hi);
         for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
            if (n == 20 && (seg == 2 || seg == 4)) hold_requests <= hold_requests + 1;
            offer_item(next_random_item(), 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (failure_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
